FILE: rtl/urx_pkg.sv
// Package for the UART receive ring block: operation and command codes,
// error flag positions and the command and result word types.
// No dependencies.
package urx_pkg;

    // operation codes on the input port
    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // command kinds after classification
    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_BAD   = 3'd1;
    localparam logic [2:0] K_RX    = 3'd2;
    localparam logic [2:0] K_READ  = 3'd3;
    localparam logic [2:0] K_QUERY = 3'd4;

    // error flag bit positions
    localparam int ERR_BIT_PE  = 0;
    localparam int ERR_BIT_FE  = 1;
    localparam int ERR_BIT_NE  = 2;
    localparam int ERR_BIT_ORE = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] ch;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [3:0] err;
        logic [6:0] limit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] result_channel;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
        logic [7:0] fill_count;
        logic [5:0] timeout_mask;
        logic [3:0] error_flags;
        logic       overflow;
        logic       restarted;
    } t_res;

endpackage

FILE: rtl/uart_rx_ring_idle_timeout_core.sv
// Top level of the multi-channel UART receive ring with idle-frame timeout.
// Depends on urx_pkg, urx_front, urx_cmdq, urx_back and urx_resq.
//
// Both sides behave as queues: a word goes in at an edge with push high and
// full low, and a result word leaves at an edge with pop high and empty low.
// Incoming words are classified and wait in a two-entry command queue; the
// back end runs one command at a time against a ring memory with separate
// write and read ports and feeds a four-entry result queue. A receive
// event, tick, fill query or bad-channel command is answered from the idle
// state, as is a read that pops nothing; otherwise each popped byte passes
// an address state, then registered memory data from the one read port.
// The back end stalls while the result queue is full. A full ring drops
// the new byte and flags overflow.
// No clearing pass follows reset: ring entries are only read once written.
// idle_timeout resets to 10 and is written through i_cfg_we / i_cfg_wdata.
module uart_rx_ring_idle_timeout_core #(
    parameter int CHANNELS   = 6,
    parameter int RING_DEPTH = 256,
    parameter int MAX_READ   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_channel,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_valid,
    input  logic        i_parity_error,
    input  logic        i_frame_error,
    input  logic        i_noise_error,
    input  logic        i_overrun_error,
    input  logic [6:0]  i_read_limit,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_result_channel,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_last,
    output logic [7:0]  o_fill_count,
    output logic [5:0]  o_timeout_mask,
    output logic [3:0]  o_error_flags,
    output logic        o_overflow,
    output logic        o_restarted
);
    import urx_pkg::*;

    t_cmd front_cmd, q_cmd;
    t_res back_res, q_res;
    logic cmd_empty, cmd_pop, res_push, res_full;

    // classify incoming words
    urx_front #(
        .CHANNELS (CHANNELS),
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_operation     (i_operation),
        .i_channel       (i_channel),
        .i_rx_byte       (i_rx_byte),
        .i_rx_valid      (i_rx_valid),
        .i_parity_error  (i_parity_error),
        .i_frame_error   (i_frame_error),
        .i_noise_error   (i_noise_error),
        .i_overrun_error (i_overrun_error),
        .i_read_limit    (i_read_limit),
        .o_cmd           (front_cmd)
    );

    // decouple front and back
    urx_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_data  (q_cmd),
        .o_empty (cmd_empty)
    );

    // execute commands
    urx_back #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (q_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .i_res_full  (res_full)
    );

    // hold results for the consumer
    urx_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_data  (q_res),
        .o_empty (empty)
    );

    assign o_result_channel = q_res.result_channel;
    assign o_data_byte      = q_res.data_byte;
    assign o_data_valid     = q_res.data_valid;
    assign o_last           = q_res.last;
    assign o_fill_count     = q_res.fill_count;
    assign o_timeout_mask   = q_res.timeout_mask;
    assign o_error_flags    = q_res.error_flags;
    assign o_overflow       = q_res.overflow;
    assign o_restarted      = q_res.restarted;

endmodule

FILE: rtl/urx_front.sv
// Front end: classifies an incoming word into a command for the back end.
// Depends on urx_pkg.
module urx_front #(
    parameter int CHANNELS = 6,
    parameter int MAX_READ = 64
) (
    input  logic [1:0]    i_operation,
    input  logic [2:0]    i_channel,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_rx_valid,
    input  logic          i_parity_error,
    input  logic          i_frame_error,
    input  logic          i_noise_error,
    input  logic          i_overrun_error,
    input  logic [6:0]    i_read_limit,
    output urx_pkg::t_cmd o_cmd
);
    import urx_pkg::*;

    localparam logic [6:0] MAX_LIM = 7'(MAX_READ);

    logic ch_ok;

    assign ch_ok = ({1'b0, i_channel} < 4'(CHANNELS));

    // sort the word by operation and channel range
    always_comb begin
        o_cmd                  = '0;
        o_cmd.ch               = i_channel;
        o_cmd.rx_byte          = i_rx_byte;
        o_cmd.rx_valid         = i_rx_valid;
        o_cmd.err[ERR_BIT_PE]  = i_parity_error;
        o_cmd.err[ERR_BIT_FE]  = i_frame_error;
        o_cmd.err[ERR_BIT_NE]  = i_noise_error;
        o_cmd.err[ERR_BIT_ORE] = i_overrun_error;
        o_cmd.limit            = (i_read_limit > MAX_LIM) ? MAX_LIM : i_read_limit;
        if (i_operation == OP_TICK) begin
            o_cmd.kind = K_TICK;
            o_cmd.ch   = 3'd0;
        end else if (!ch_ok) begin
            o_cmd.kind = K_BAD;
        end else begin
            case (i_operation)
                OP_RX:    o_cmd.kind = K_RX;
                OP_READ:  o_cmd.kind = K_READ;
                OP_QUERY: o_cmd.kind = K_QUERY;
                default:  o_cmd.kind = K_TICK;
            endcase
        end
    end

endmodule

FILE: rtl/urx_cmdq.sv
// Short command queue between front end and back end.
// Depends on urx_pkg.
module urx_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  urx_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_rd,
    output urx_pkg::t_cmd o_data,
    output logic          o_empty
);
    import urx_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = 1;

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // store incoming commands
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_wr && !o_full) - (AW+1)'(i_rd && !o_empty);
        end
    end

endmodule

FILE: rtl/urx_resq.sv
// Result queue that holds finished result words until they are popped.
// Depends on urx_pkg.
module urx_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  urx_pkg::t_res i_data,
    output logic          o_full,
    input  logic          i_rd,
    output urx_pkg::t_res o_data,
    output logic          o_empty
);
    import urx_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = 2;

    t_res          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // store result words
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_wr && !o_full) - (AW+1)'(i_rd && !o_empty);
        end
    end

endmodule

FILE: rtl/urx_back.sv
// Back end: executes commands against the channel rings, pointers,
// idle countdowns and busy flags, and emits result words.
// Depends on urx_pkg.
module urx_back #(
    parameter int CHANNELS   = 6,
    parameter int RING_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  urx_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output logic          o_res_push,
    output urx_pkg::t_res o_res,
    input  logic          i_res_full
);
    import urx_pkg::*;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [MEM_AW-1:0] RING_M = MEM_AW'(RING_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RREQ = 2'd1;
    localparam logic [1:0] S_RDAT = 2'd2;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] wr,
                                                  input logic [PTR_W-1:0] rd);
        logic [PTR_W:0] d;
        if (wr >= rd) begin
            d = {1'b0, wr} - {1'b0, rd};
        end else begin
            d = (PTR_W+1)'(RING_DEPTH) + {1'b0, wr} - {1'b0, rd};
        end
        return d[PTR_W-1:0];
    endfunction

    logic [7:0]       r_ring [MEM_DEPTH];
    logic [7:0]       r_mem_q;
    logic [PTR_W-1:0] r_rd_ptr [CHANNELS];
    logic [PTR_W-1:0] r_wr_ptr [CHANNELS];
    logic [15:0]      r_cnt    [CHANNELS];
    logic [CHANNELS-1:0] r_busy;
    logic [PTR_W-1:0] n_rd_ptr [CHANNELS];
    logic [PTR_W-1:0] n_wr_ptr [CHANNELS];
    logic [15:0]      n_cnt    [CHANNELS];
    logic [CHANNELS-1:0] n_busy;
    logic [15:0]      r_timeout;
    logic [1:0]       r_state, n_state;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [2:0]       r_res_ch, n_res_ch;
    logic [6:0]       r_left, n_left;
    logic             r_last, n_last;
    logic [PTR_W-1:0] r_fill, n_fill;

    logic             mem_we, mem_re;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [CH_W-1:0]  cmd_ch;
    logic [PTR_W-1:0] cur_rd, cur_wr, nxt_wr, rq_rd, rq_nrd, rq_wr;
    logic [7:0]       tmask;

    assign cmd_ch = i_cmd.ch[CH_W-1:0];
    assign cur_rd = r_rd_ptr[cmd_ch];
    assign cur_wr = r_wr_ptr[cmd_ch];
    assign nxt_wr = next_ptr(cur_wr);
    assign rq_rd  = r_rd_ptr[r_ch];
    assign rq_wr  = r_wr_ptr[r_ch];
    assign rq_nrd = next_ptr(rq_rd);

    assign mem_waddr = MEM_AW'(MEM_AW'(cmd_ch) * RING_M + MEM_AW'(cur_wr));
    assign mem_raddr = MEM_AW'(MEM_AW'(r_ch) * RING_M + MEM_AW'(rq_rd));

    // sequence commands and build result words
    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        n_state    = r_state;
        n_ch       = r_ch;
        n_res_ch   = r_res_ch;
        n_left     = r_left;
        n_last     = r_last;
        n_fill     = r_fill;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        tmask      = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop            = 1'b1;
                    o_res.result_channel = i_cmd.ch;
                    o_res.last           = 1'b1;
                    case (i_cmd.kind)
                        K_TICK: begin
                            for (int i = 0; i < CHANNELS; i++) begin
                                if (r_busy[i]) begin
                                    if (r_cnt[i] != 16'd0) begin
                                        n_cnt[i] = r_cnt[i] - 16'd1;
                                    end else begin
                                        n_busy[i] = 1'b0;
                                        tmask[i]  = 1'b1;
                                    end
                                end
                            end
                            o_res.result_channel = 3'd0;
                            o_res.timeout_mask   = tmask[5:0];
                            o_res_push           = 1'b1;
                        end
                        K_RX: begin
                            o_res.error_flags = i_cmd.err;
                            o_res.restarted   = i_cmd.err[ERR_BIT_ORE];
                            o_res.fill_count  = 8'(fill_of(cur_wr, cur_rd));
                            if (i_cmd.rx_valid) begin
                                if (nxt_wr == cur_rd) begin
                                    o_res.overflow = 1'b1;
                                end else begin
                                    mem_we           = 1'b1;
                                    n_wr_ptr[cmd_ch] = nxt_wr;
                                    o_res.fill_count = 8'(fill_of(nxt_wr, cur_rd));
                                end
                                n_cnt[cmd_ch]  = r_timeout;
                                n_busy[cmd_ch] = 1'b1;
                            end
                            o_res_push = 1'b1;
                        end
                        K_READ: begin
                            if (i_cmd.limit == 7'd0 || cur_rd == cur_wr) begin
                                o_res.fill_count = 8'(fill_of(cur_wr, cur_rd));
                                o_res_push       = 1'b1;
                            end else begin
                                n_ch     = cmd_ch;
                                n_res_ch = i_cmd.ch;
                                n_left   = i_cmd.limit;
                                n_state  = S_RREQ;
                            end
                        end
                        K_QUERY: begin
                            o_res.fill_count = 8'(fill_of(cur_wr, cur_rd));
                            o_res_push       = 1'b1;
                        end
                        default: begin
                            // channel out of range: channel and last only
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_RREQ: begin
                // fetch the oldest byte and pop it
                mem_re         = 1'b1;
                n_rd_ptr[r_ch] = rq_nrd;
                n_last         = (r_left == 7'd1) || (rq_nrd == rq_wr);
                n_fill         = fill_of(rq_wr, rq_nrd);
                n_state        = S_RDAT;
            end
            S_RDAT: begin
                if (!i_res_full) begin
                    o_res.result_channel = r_res_ch;
                    o_res.data_byte      = r_mem_q;
                    o_res.data_valid     = 1'b1;
                    o_res.last           = r_last;
                    o_res.fill_count     = 8'(r_fill);
                    o_res_push           = 1'b1;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left  = r_left - 7'd1;
                        n_state = S_RREQ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ring memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= i_cmd.rx_byte;
        end
        if (mem_re) begin
            r_mem_q <= r_ring[mem_raddr];
        end
    end

    // hold read sequence payload
    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_res_ch <= n_res_ch;
        r_left   <= n_left;
        r_last   <= n_last;
        r_fill   <= n_fill;
    end

    // channel state, timeout register and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= 16'd10;
            r_busy    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_rd_ptr[i] <= '0;
                r_wr_ptr[i] <= '0;
                r_cnt[i]    <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_cnt    <= n_cnt;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

endmodule
